FILE: design/slm_pkg.sv
package slm_pkg;

    localparam int MAX_REGION_WIDTH  = 1024;
    localparam int MAX_REGION_HEIGHT = 1024;
    localparam int GAMMA_ENTRIES     = 32;

    localparam int PIX_W     = 16;
    localparam int CH_W      = 5;
    localparam int GAMMA_AW  = $clog2(GAMMA_ENTRIES);
    localparam int GAMMA_W   = 17;
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam int POS_W = $clog2(MAX_REGION_WIDTH);
    localparam int ROW_W = $clog2(MAX_REGION_HEIGHT);
    localparam int WC_W  = $clog2(MAX_REGION_WIDTH + 1);
    localparam int HC_W  = $clog2(MAX_REGION_HEIGHT + 1);
    localparam int CNT_W = $clog2(MAX_REGION_WIDTH * MAX_REGION_HEIGHT + 1);

    localparam int LUM_K_W = 10;
    localparam int SUM_W   = GAMMA_W - 1 + CNT_W;
    localparam int PROD_W  = GAMMA_W + LUM_K_W;
    localparam int WSUM_W  = SUM_W + LUM_K_W;
    localparam int DEN_W   = CNT_W + LUM_K_W;
    localparam int DEN2_W  = DEN_W + 1;
    localparam int NUM_W   = WSUM_W + 1;
    localparam int Q_W     = GAMMA_W;
    localparam int DIV_W   = (NUM_W > DEN2_W + Q_W - 1) ? NUM_W : DEN2_W + Q_W - 1;
    localparam int QCNT_W  = $clog2(Q_W + 1);

    localparam int IN_TDATA_W  = ((PIX_W + GAMMA_AW + GAMMA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((PIX_W + 4 * GAMMA_W + 7) / 8) * 8;

    localparam logic [GAMMA_W-1:0] GAMMA_MAX  = GAMMA_W'(65536);
    localparam logic [DIM_W-1:0]   RST_WIDTH  = DIM_W'(320);
    localparam logic [DIM_W-1:0]   RST_HEIGHT = DIM_W'(240);

    localparam logic [LUM_K_W-1:0] LUM_R     = LUM_K_W'(299);
    localparam logic [LUM_K_W-1:0] LUM_G     = LUM_K_W'(587);
    localparam logic [LUM_K_W-1:0] LUM_B     = LUM_K_W'(114);
    localparam logic [LUM_K_W-1:0] LUM_SCALE = LUM_K_W'(1000);

    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_TABLE   = 1'b1;

    localparam logic FMT_565 = 1'b0;
    localparam logic FMT_555 = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        DIV_RED,
        DIV_GREEN,
        DIV_BLUE,
        DIV_LUM
    } t_div_sel;

    typedef struct packed {
        logic     accept;
        logic     accum;
        logic     wsum;
        logic     div_start;
        logic     div_store;
        logic     restart;
        logic     out_load;
        t_div_sel div_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic is_table;
        logic empty;
        logic last;
        logic div_done;
    } t_dp_sts;

endpackage

FILE: design/slm_ram.sv
module slm_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/slm_divider.sv
module slm_divider import slm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN2_W-1:0] i_den2,
    output logic              o_done,
    output logic [Q_W-1:0]    o_quotient
);

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_div;
    logic [Q_W-1:0]    r_quo;
    logic [QCNT_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic              w_fit;

    assign w_fit = r_rem >= r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_step <= QCNT_W'(Q_W);
            end else if (r_busy) begin
                r_step <= r_step - QCNT_W'(1);
                r_done <= (r_step == QCNT_W'(1));
                if (r_step == QCNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DIV_W'(i_num);
            r_div <= DIV_W'(i_den2) << (Q_W - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - r_div;
            end
            r_div <= r_div >> 1;
            r_quo <= {r_quo[Q_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: design/slm_datapath.sv
module slm_datapath import slm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_command,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic [GAMMA_AW-1:0]  i_table_index,
    input  logic [GAMMA_W-1:0]   i_table_value,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic [PIX_W-1:0]     o_pixel_out,
    output logic                 o_frame_done,
    output logic [GAMMA_W-1:0]   o_avg_red,
    output logic [GAMMA_W-1:0]   o_avg_green,
    output logic [GAMMA_W-1:0]   o_avg_blue,
    output logic [GAMMA_W-1:0]   o_luminance
);

    logic               r_fmt;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [POS_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_red_sum;
    logic [SUM_W-1:0]   r_green_sum;
    logic [SUM_W-1:0]   r_blue_sum;
    logic [WSUM_W-1:0]  r_wsum;
    logic [PROD_W-1:0]  r_prod_r;
    logic [PROD_W-1:0]  r_prod_g;
    logic [PROD_W-1:0]  r_prod_b;
    logic [DEN_W-1:0]   r_den;
    logic               r_last;
    logic [PIX_W-1:0]   r_res_pix;
    logic               r_res_done;
    logic [GAMMA_W-1:0] r_res_avg [4];
    logic [PIX_W-1:0]   r_out_pix;
    logic               r_out_done;
    logic [GAMMA_W-1:0] r_out_avg [4];

    logic [WC_W-1:0]    w_w_eff;
    logic [HC_W-1:0]    w_h_eff;
    logic               w_empty;
    logic               w_col_end;
    logic               w_row_end;
    logic               w_border;
    logic               w_meas;
    logic               w_cfg_restart;
    logic [CH_W-1:0]    w_ch_r;
    logic [CH_W-1:0]    w_ch_g;
    logic [CH_W-1:0]    w_ch_b;
    logic [GAMMA_W-1:0] w_gam_r;
    logic [GAMMA_W-1:0] w_gam_g;
    logic [GAMMA_W-1:0] w_gam_b;
    logic [GAMMA_W-1:0] w_tbl_val;
    logic               w_tbl_we;
    logic [NUM_W-1:0]   w_div_num;
    logic [DEN2_W-1:0]  w_div_den2;
    logic               w_div_done;
    logic [Q_W-1:0]     w_quo;

    always_comb begin
        if (32'(r_width) > 32'(MAX_REGION_WIDTH)) begin
            w_w_eff = WC_W'(MAX_REGION_WIDTH);
        end else begin
            w_w_eff = WC_W'(r_width);
        end
        if (32'(r_height) > 32'(MAX_REGION_HEIGHT)) begin
            w_h_eff = HC_W'(MAX_REGION_HEIGHT);
        end else begin
            w_h_eff = HC_W'(r_height);
        end
    end

    assign w_empty   = (w_w_eff == '0) || (w_h_eff == '0);
    assign w_col_end = (WC_W'(r_col) + WC_W'(1)) >= w_w_eff;
    assign w_row_end = (HC_W'(r_row) + HC_W'(1)) >= w_h_eff;
    assign w_border  = (r_row == '0) || (r_col == '0) || w_col_end || w_row_end;
    assign w_meas    = i_cmd.accept && (i_command == CMD_MEASURE) && !w_empty;
    assign w_tbl_we  = i_cmd.accept && (i_command == CMD_TABLE);
    assign w_tbl_val = (i_table_value > GAMMA_MAX) ? GAMMA_MAX : i_table_value;

    assign w_cfg_restart = i_cfg_valid &&
        (i_cfg_index inside {CFG_PIXEL_FORMAT, CFG_REGION_WIDTH, CFG_REGION_HEIGHT});

    always_comb begin
        if (r_fmt == FMT_555) begin
            w_ch_r = i_pixel[14:10];
            w_ch_g = i_pixel[9:5];
        end else begin
            w_ch_r = i_pixel[15:11];
            w_ch_g = i_pixel[10:6];
        end
        w_ch_b = i_pixel[4:0];
    end

    slm_ram #(.WIDTH(GAMMA_W), .DEPTH(GAMMA_ENTRIES)) u_ram_r (
        .i_clk   (i_clk),
        .i_we    (w_tbl_we),
        .i_waddr (i_table_index),
        .i_wdata (w_tbl_val),
        .i_raddr (GAMMA_AW'(w_ch_r)),
        .o_rdata (w_gam_r)
    );

    slm_ram #(.WIDTH(GAMMA_W), .DEPTH(GAMMA_ENTRIES)) u_ram_g (
        .i_clk   (i_clk),
        .i_we    (w_tbl_we),
        .i_waddr (i_table_index),
        .i_wdata (w_tbl_val),
        .i_raddr (GAMMA_AW'(w_ch_g)),
        .o_rdata (w_gam_g)
    );

    slm_ram #(.WIDTH(GAMMA_W), .DEPTH(GAMMA_ENTRIES)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_tbl_we),
        .i_waddr (i_table_index),
        .i_wdata (w_tbl_val),
        .i_raddr (GAMMA_AW'(w_ch_b)),
        .o_rdata (w_gam_b)
    );

    always_comb begin
        case (i_cmd.div_sel)
            DIV_RED: begin
                w_div_num  = NUM_W'({r_red_sum, 1'b0}) + NUM_W'(r_count);
                w_div_den2 = DEN2_W'({r_count, 1'b0});
            end
            DIV_GREEN: begin
                w_div_num  = NUM_W'({r_green_sum, 1'b0}) + NUM_W'(r_count);
                w_div_den2 = DEN2_W'({r_count, 1'b0});
            end
            DIV_BLUE: begin
                w_div_num  = NUM_W'({r_blue_sum, 1'b0}) + NUM_W'(r_count);
                w_div_den2 = DEN2_W'({r_count, 1'b0});
            end
            default: begin
                w_div_num  = NUM_W'({r_wsum, 1'b0}) + NUM_W'(r_den);
                w_div_den2 = DEN2_W'({r_den, 1'b0});
            end
        endcase
    end

    slm_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_num      (w_div_num),
        .i_den2     (w_div_den2),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt       <= FMT_565;
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
            r_col       <= '0;
            r_row       <= '0;
            r_count     <= '0;
            r_red_sum   <= '0;
            r_green_sum <= '0;
            r_blue_sum  <= '0;
            r_wsum      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_PIXEL_FORMAT:  r_fmt    <= i_cfg_data[0];
                    CFG_REGION_WIDTH:  r_width  <= i_cfg_data;
                    CFG_REGION_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.restart || w_cfg_restart) begin
                r_col       <= '0;
                r_row       <= '0;
                r_count     <= '0;
                r_red_sum   <= '0;
                r_green_sum <= '0;
                r_blue_sum  <= '0;
                r_wsum      <= '0;
            end else begin
                if (w_meas) begin
                    r_count <= r_count + CNT_W'(1);
                    if (w_col_end) begin
                        r_col <= '0;
                        if (!w_row_end) begin
                            r_row <= r_row + ROW_W'(1);
                        end
                    end else begin
                        r_col <= r_col + POS_W'(1);
                    end
                end
                if (i_cmd.accum) begin
                    r_red_sum   <= r_red_sum + SUM_W'(w_gam_r);
                    r_green_sum <= r_green_sum + SUM_W'(w_gam_g);
                    r_blue_sum  <= r_blue_sum + SUM_W'(w_gam_b);
                end
                if (i_cmd.wsum) begin
                    r_wsum <= r_wsum + WSUM_W'(r_prod_r) + WSUM_W'(r_prod_g)
                            + WSUM_W'(r_prod_b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res_avg[0] <= '0;
            r_res_avg[1] <= '0;
            r_res_avg[2] <= '0;
            r_res_avg[3] <= '0;
            if (i_command == CMD_TABLE) begin
                r_res_pix  <= '0;
                r_res_done <= 1'b0;
            end else if (w_empty) begin
                r_res_pix  <= i_pixel;
                r_res_done <= 1'b1;
            end else begin
                r_res_pix  <= w_border ? ~i_pixel : i_pixel;
                r_res_done <= w_col_end && w_row_end;
            end
            r_last <= w_col_end && w_row_end;
        end
        if (i_cmd.accum) begin
            r_prod_r <= PROD_W'(w_gam_r) * PROD_W'(LUM_R);
            r_prod_g <= PROD_W'(w_gam_g) * PROD_W'(LUM_G);
            r_prod_b <= PROD_W'(w_gam_b) * PROD_W'(LUM_B);
        end
        if (i_cmd.wsum) begin
            r_den <= DEN_W'(r_count) * DEN_W'(LUM_SCALE);
        end
        if (i_cmd.div_store) begin
            r_res_avg[i_cmd.div_sel] <= w_quo;
        end
        if (i_cmd.out_load) begin
            r_out_pix    <= r_res_pix;
            r_out_done   <= r_res_done;
            r_out_avg[0] <= r_res_avg[0];
            r_out_avg[1] <= r_res_avg[1];
            r_out_avg[2] <= r_res_avg[2];
            r_out_avg[3] <= r_res_avg[3];
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.is_table = (i_command == CMD_TABLE);
        o_sts.empty    = w_empty;
        o_sts.last     = r_last;
        o_sts.div_done = w_div_done;
    end

    assign o_pixel_out  = r_out_pix;
    assign o_frame_done = r_out_done;
    assign o_avg_red    = r_out_avg[0];
    assign o_avg_green  = r_out_avg[1];
    assign o_avg_blue   = r_out_avg[2];
    assign o_luminance  = r_out_avg[3];

endmodule

FILE: design/slm_ctrl.sv
module slm_ctrl import slm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCUM,
        S_WSUM,
        S_DIV_START,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    t_state   r_state;
    t_div_sel r_div_sel;
    logic     r_out_valid;
    logic     w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.div_sel   = r_div_sel;
        o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.accum     = (r_state == S_ACCUM);
        o_cmd.wsum      = (r_state == S_WSUM);
        o_cmd.div_start = (r_state == S_DIV_START);
        o_cmd.div_store = (r_state == S_DIV_WAIT) && i_sts.div_done;
        o_cmd.restart   = o_cmd.div_store && (r_div_sel == DIV_LUM);
        o_cmd.out_load  = (r_state == S_EMIT) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_sel   <= DIV_RED;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !o_cmd.out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= (i_sts.is_table || i_sts.empty) ? S_EMIT : S_ACCUM;
                    end
                end
                S_ACCUM: begin
                    r_state <= S_WSUM;
                end
                S_WSUM: begin
                    r_div_sel <= DIV_RED;
                    r_state   <= i_sts.last ? S_DIV_START : S_EMIT;
                end
                S_DIV_START: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (i_sts.div_done) begin
                        if (r_div_sel == DIV_LUM) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_div_sel <= t_div_sel'(r_div_sel + 2'd1);
                            r_state   <= S_DIV_START;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: design/screen_luminance_meter_top.sv
// A pixel beat steps the controller through ACCUM, WSUM and EMIT; no new beat is taken
// until EMIT has loaded its result into the output register. Table beats and empty-region
// pixels skip to EMIT. A region-closing pixel adds four divisions on one shared divider.
// A result waiting in the output register stalls only the controller's final step.
// Reset is synchronous, active low: clears control, positions, sums and count, and sets
// 565 format, 320 x 240; the gamma table is not cleared and holds garbage until loaded.
module screen_luminance_meter_top import slm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pixel[15:0], table_index[20:16], table_value[37:21], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command[0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pixel_out[15:0], avg_red[32:16], avg_green[49:33], avg_blue[66:50],
    // luminance[83:67], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [DIM_W-1:0]       i_cfg_data
);

    t_dp_cmd            w_cmd;
    t_dp_sts            w_sts;
    logic [PIX_W-1:0]   w_pixel_out;
    logic [GAMMA_W-1:0] w_avg_red;
    logic [GAMMA_W-1:0] w_avg_green;
    logic [GAMMA_W-1:0] w_avg_blue;
    logic [GAMMA_W-1:0] w_luminance;

    slm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    slm_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_command     (s_axis_tuser),
        .i_pixel       (s_axis_tdata[PIX_W-1:0]),
        .i_table_index (s_axis_tdata[PIX_W+GAMMA_AW-1:PIX_W]),
        .i_table_value (s_axis_tdata[PIX_W+GAMMA_AW+GAMMA_W-1:PIX_W+GAMMA_AW]),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_pixel_out   (w_pixel_out),
        .o_frame_done  (m_axis_tlast),
        .o_avg_red     (w_avg_red),
        .o_avg_green   (w_avg_green),
        .o_avg_blue    (w_avg_blue),
        .o_luminance   (w_luminance)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = OUT_TDATA_W'({w_luminance, w_avg_blue, w_avg_green, w_avg_red,
                                        w_pixel_out});

`ifndef SYNTH
    a_stats_zero_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            (w_avg_red == '0) && (w_avg_green == '0) && (w_avg_blue == '0) &&
            (w_luminance == '0))
        else $error("statistics nonzero on a beat that does not close the region");

    a_one_beat_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again before the previous beat finished");

    a_div_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.div_done |-> !s_axis_tready && !w_cmd.accept)
        else $error("divider finished while input was open");
`endif

endmodule
